// ===== hdl/gmtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmtt_pkg: shared types and constants for the gated multi timer tick core
// Mode word layout, clock event record and gate mode codes.
// ----------------------------------------------------------------------------
package gmtt_pkg;

    localparam int MODE_W   = 10;
    localparam int TARGET_W = 16;
    localparam int CMP_W    = 32;

    localparam logic [1:0] SRC_HBLANK = 2'd3;

    typedef enum logic [1:0] {
        GATE_LEVEL = 2'd0,
        GATE_RISE  = 2'd1,
        GATE_FALL  = 2'd2,
        GATE_BOTH  = 2'd3
    } gate_mode_t;

    // Packed MSB first so that bit 0 of the word is clksel[0].
    typedef struct packed {
        logic       ovf_irq;
        logic       cmp_irq;
        logic       count_en;
        logic       zero_ret;
        gate_mode_t gate_mode;
        logic       gate_sel;
        logic       gate_en;
        logic [1:0] clksel;
    } mode_t;

    typedef struct packed {
        logic [1:0] clock_source;
        logic       hblank_level;
        logic       vblank_level;
        logic       hblank_prev;
        logic       vblank_prev;
    } clk_event_t;

endpackage

// ===== hdl/gated_multi_timer_tick_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_multi_timer_tick_core: up to four gated compare/overflow timers
// Datapath: the event item is captured in the input register, then its result
// in the result register; a stalled result holds the input register.
// Throughput: one event item per cycle while the result is not stalled; counts
// update in a single pass between the input register and the result register.
// Reset (aresetn low, synchronous): mode, target and count registers clear,
// both valid flags drop.
// ----------------------------------------------------------------------------
module gated_multi_timer_tick_core #(
    parameter int NUM_TIMERS  = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // event channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // hblank_level, vblank_level, hblank_prev, vblank_prev, pad
    input  logic [1:0]  s_tuser,  // clock_source
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // irq_set[3:0], count0, count1, count2, count3, pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOTS = 4;
    localparam logic [2:0] REG_TARGET0 = 3'd4;

    gmtt_pkg::mode_t                  mode_reg   [SLOTS];
    logic [gmtt_pkg::TARGET_W-1:0]    target_reg [SLOTS];
    logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_reg;
    logic [NUM_TIMERS-1:0][COUNT_WIDTH-1:0] count_next;
    logic [NUM_TIMERS-1:0]            irq_vec;

    gmtt_pkg::clk_event_t             ev_reg;
    logic                             in_valid_reg;
    logic                             m_tvalid_reg;
    logic [71:0]                      m_tdata_reg;
    logic [71:0]                      m_tdata_next;
    logic [3:0]                       irq_next;
    logic [SLOTS-1:0][15:0]           cnt_out;

    logic       adv;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                mode_reg[i]   <= '0;
                target_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            if (cfg_idx < REG_TARGET0) begin
                mode_reg[cfg_idx[1:0]] <= gmtt_pkg::mode_t'(pwdata[gmtt_pkg::MODE_W-1:0]);
            end else begin
                target_reg[cfg_idx[1:0]] <= pwdata[gmtt_pkg::TARGET_W-1:0];
            end
        end
    end

    always_comb begin
        if (cfg_idx < REG_TARGET0) begin
            prdata = 32'(mode_reg[cfg_idx[1:0]]);
        end else begin
            prdata = 32'(target_reg[cfg_idx[1:0]]);
        end
    end

    // ---------------- handshake ----------------
    assign adv      = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    // hold the event payload until it is consumed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ev_reg.clock_source <= s_tuser;
            ev_reg.hblank_level <= s_tdata[0];
            ev_reg.vblank_level <= s_tdata[1];
            ev_reg.hblank_prev  <= s_tdata[2];
            ev_reg.vblank_prev  <= s_tdata[3];
        end
    end

    // ---------------- timers ----------------
    for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
        gmtt_timer_unit #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_timer (
            .mode    (mode_reg[t]),
            .target  (target_reg[t]),
            .ev      (ev_reg),
            .cnt_in  (count_reg[t]),
            .cnt_out (count_next[t]),
            .irq     (irq_vec[t])
        );
    end

    for (genvar t = 0; t < SLOTS; t++) begin : g_slot
        if (t < NUM_TIMERS) begin : g_used
            assign cnt_out[t]  = 16'(count_next[t]);
            assign irq_next[t] = irq_vec[t];
        end else begin : g_unused
            assign cnt_out[t]  = '0;
            assign irq_next[t] = 1'b0;
        end
    end

    assign m_tdata_next = {4'b0000, cnt_out[3], cnt_out[2], cnt_out[1], cnt_out[0], irq_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (adv) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // ---------------- assertions ----------------
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(count_reg))
        else $error("timer count changed without a consumed item");

    a_adv_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid)
        else $error("consumed item produced no result");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |-> !s_tready)
        else $error("input register would be overwritten");

    a_unused_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:0] >> NUM_TIMERS) == 4'd0))
        else $error("interrupt raised by an absent timer");

endmodule

// ===== hdl/gmtt_timer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmtt_timer_unit: next-count logic of one timer
// Gate clear or hold, increment with wrap, compare and zero return.
// ----------------------------------------------------------------------------
module gmtt_timer_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  gmtt_pkg::mode_t             mode,
    input  logic [gmtt_pkg::TARGET_W-1:0] target,
    input  gmtt_pkg::clk_event_t        ev,
    input  logic [COUNT_WIDTH-1:0]      cnt_in,
    output logic [COUNT_WIDTH-1:0]      cnt_out,
    output logic                        irq
);

    logic                   sel;
    logic                   gate_active;
    logic                   now_lvl;
    logic                   before_lvl;
    logic                   rise;
    logic                   fall;
    logic                   clr;
    logic                   hold;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic [COUNT_WIDTH-1:0] cnt_a;
    logic                   wrapped;
    logic                   ge;

    always_comb begin
        sel = mode.count_en && (mode.clksel == ev.clock_source);
        // hblank clock gated by hblank runs ungated
        gate_active = mode.gate_en &&
                      !(mode.clksel == gmtt_pkg::SRC_HBLANK && !mode.gate_sel);
        now_lvl    = mode.gate_sel ? ev.vblank_level : ev.hblank_level;
        before_lvl = mode.gate_sel ? ev.vblank_prev  : ev.hblank_prev;
        rise = now_lvl && !before_lvl;
        fall = !now_lvl && before_lvl;

        clr = 1'b0;
        case (mode.gate_mode)
            gmtt_pkg::GATE_RISE:  clr = rise;
            gmtt_pkg::GATE_FALL:  clr = fall;
            gmtt_pkg::GATE_BOTH:  clr = rise || fall;
            default:              clr = 1'b0;
        endcase
        clr  = clr && gate_active;
        hold = gate_active && (mode.gate_mode == gmtt_pkg::GATE_LEVEL) && now_lvl;

        base    = clr ? '0 : cnt_in;
        inc_val = base + COUNT_WIDTH'(1);
        wrapped = !hold && (inc_val == '0);
        cnt_a   = hold ? base : inc_val;

        ge  = gmtt_pkg::CMP_W'(cnt_a) >= gmtt_pkg::CMP_W'(target);
        irq = sel && ((mode.cmp_irq && ge) || (mode.ovf_irq && wrapped));

        if (!sel) begin
            cnt_out = cnt_in;
        end else if (mode.zero_ret && ge) begin
            cnt_out = '0;
        end else begin
            cnt_out = cnt_a;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: gated multi timer tick core
// Feeds clock event items through the stream port and programs the timers over
// the register port while the core is idle. A directed table covers gating,
// hblank self-gating, compare and zero-return. A long back-to-back run on the
// bus clock follows, then randomly configured phases. Each result is checked against
// a table value or a timer model kept here, with sender gaps and receiver stalls in most phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_ITEMS     = 226;
    localparam int LONG_ITEMS      = 300;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DIR_ROWS        = 36;
    localparam longint TIMEOUT_NS  = 2_000_000;

    // clock sources other than hblank
    localparam logic [1:0] SRC_BUS    = 2'd0;
    localparam logic [1:0] SRC_BUS16  = 2'd1;
    localparam logic [1:0] SRC_BUS256 = 2'd2;

    // mode word bits
    localparam logic [9:0] M_GATE  = 10'h004;
    localparam logic [9:0] M_VGATE = 10'h008;
    localparam logic [9:0] M_ZRET  = 10'h040;
    localparam logic [9:0] M_CNT   = 10'h080;
    localparam logic [9:0] M_CMP   = 10'h100;
    localparam logic [9:0] M_OVF   = 10'h200;
    localparam logic [9:0] M_RISE  = {4'b0, gmtt_pkg::GATE_RISE, 4'b0};
    localparam logic [9:0] M_FALL  = {4'b0, gmtt_pkg::GATE_FALL, 4'b0};
    localparam logic [9:0] M_BOTH  = {4'b0, gmtt_pkg::GATE_BOTH, 4'b0};
    localparam logic [9:0] M_HBCLK = {8'b0, gmtt_pkg::SRC_HBLANK};
    localparam logic [9:0] M_B16   = {8'b0, SRC_BUS16};
    localparam logic [9:0] M_B256  = {8'b0, SRC_BUS256};

    typedef enum logic [2:0] {
        REG_MODE0, REG_MODE1, REG_MODE2, REG_MODE3,
        REG_TARGET0, REG_TARGET1, REG_TARGET2, REG_TARGET3
    } reg_idx_t;

    typedef enum logic { ROW_CONFIG, ROW_EVENT } row_kind_t;

    typedef struct packed {
        logic [3:0]       irq_set;
        logic [3:0][15:0] count;
    } tick_result_t;

    typedef struct packed {
        logic         typed;
        tick_result_t value;
    } known_t;

    typedef struct packed {
        row_kind_t    kind;
        reg_idx_t     idx;
        logic [15:0]  value;
        logic [1:0]   src;
        logic [3:0]   levels;  // vblank_prev, hblank_prev, vblank, hblank
        known_t       known;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // hblank_level, vblank_level, hblank_prev, vblank_prev, pad
    logic [1:0]  s_tuser = '0;   // clock_source
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // irq_set[3:0], count0, count1, count2, count3, pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // timer model
    gmtt_pkg::mode_t timer_mode   [4];
    logic [15:0]     timer_target [4];
    logic [15:0]     timer_count  [4];

    tick_result_t expected_ticks[$];
    known_t       known_ticks[$];

    dir_row_t directed_rows [DIR_ROWS];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  events_sent    = 0;
    int  config_writes  = 0;
    int  ready_pct      = 70;
    int  burst_left     = 0;
    bit  sender_gappy   = 1'b1;
    int  holds_asked    = 0;
    int  holds_granted  = 0;
    int  hold_left      = 0;

    gated_multi_timer_tick_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Advance all four timers by one clock event and return what the core reports.
    function automatic tick_result_t advance_timers(input logic [1:0] src,
                                                   input logic [3:0] levels);
        tick_result_t    r;
        gmtt_pkg::mode_t m;
        logic [15:0]     cnt;
        logic            gate_now, gate_was, step, wrapped;
        r = '0;
        for (int t = 0; t < 4; t++) begin
            m = timer_mode[t];
            cnt = timer_count[t];
            if (m.count_en && m.clksel == src) begin
                step = 1'b1;
                wrapped = 1'b0;
                // an hblank-clocked timer ignores its own hblank gate
                if (m.gate_en && !(m.clksel == gmtt_pkg::SRC_HBLANK && !m.gate_sel)) begin
                    gate_now = m.gate_sel ? levels[1] : levels[0];
                    gate_was = m.gate_sel ? levels[3] : levels[2];
                    case (m.gate_mode)
                        gmtt_pkg::GATE_LEVEL: step = ~gate_now;
                        gmtt_pkg::GATE_RISE:  if (gate_now && !gate_was) cnt = '0;
                        gmtt_pkg::GATE_FALL:  if (!gate_now && gate_was) cnt = '0;
                        gmtt_pkg::GATE_BOTH:  if (gate_now != gate_was) cnt = '0;
                        default:              step = 1'b1;
                    endcase
                end
                if (step) begin
                    cnt = cnt + 16'd1;
                    wrapped = (cnt == 16'd0);
                end
                if ((m.cmp_irq && cnt >= timer_target[t]) || (m.ovf_irq && wrapped))
                    r.irq_set[t] = 1'b1;
                if (m.zero_ret && cnt >= timer_target[t])
                    cnt = '0;
                timer_count[t] = cnt;
            end
            r.count[t] = timer_count[t];
        end
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input reg_idx_t idx, input logic [15:0] value);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CONFIG;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic dir_row_t evt_row(input logic [1:0] src, input logic [3:0] levels);
        dir_row_t r;
        r = '0;
        r.kind = ROW_EVENT;
        r.src = src;
        r.levels = levels;
        return r;
    endfunction

    function automatic dir_row_t evt_known(input logic [1:0] src, input logic [3:0] levels,
                                           input logic [3:0] irq, input logic [15:0] c0);
        dir_row_t r;
        r = evt_row(src, levels);
        r.known.typed = 1'b1;
        r.known.value.irq_set = irq;
        r.known.value.count = {16'd0, 16'd0, 16'd0, c0};
        return r;
    endfunction

    // Register write: setup cycle, then access cycle; update the model at the write edge.
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= REG_MODE3)
            timer_mode[idx[1:0]] = gmtt_pkg::mode_t'(value[9:0]);
        else
            timer_target[idx[1:0]] = value;
        config_writes++;
        // idle state between transfers
        @(posedge aclk);
    endtask

    task automatic send_event(input logic [1:0] src, input logic [3:0] levels,
                              input known_t known);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_gappy) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        known_ticks.push_back(known);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, levels};
        s_tuser  <= src;
        do @(posedge aclk); while (!s_tready);
        events_sent++;
    endtask

    // Drop valid and wait until every result is out, so a register write is safe.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge aclk);
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [9:0]  mode;
        logic [15:0] target;
        for (int t = 0; t < 4; t++) begin
            mode = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 4) != 0)
                mode = mode | M_CNT;
            write_reg(reg_idx_t'(t), {6'd0, mode});
            case ($urandom_range(0, 5))
                0:       target = 16'd0;
                1:       target = 16'hFFFF;
                2, 3:    target = 16'($urandom_range(1, 24));
                default: target = 16'($urandom_range(0, 65535));
            endcase
            write_reg(reg_idx_t'(t + 4), target);
        end
    endtask

    // Receiver: random stall pattern, plus long hold-offs on request.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (holds_asked != holds_granted) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Predict on every accepted item, check every accepted result.
    always @(posedge aclk) begin : watch
        tick_result_t pred, want, got;
        known_t       k;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                k = '0;
                if (known_ticks.size() != 0)
                    k = known_ticks.pop_front();
                pred = advance_timers(s_tuser, s_tdata[3:0]);
                expected_ticks.push_back(k.typed ? k.value : pred);
            end
            if (m_tvalid && m_tready) begin
                got.irq_set = m_tdata[3:0];
                got.count   = m_tdata[67:4];
                results_seen++;
                if (expected_ticks.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing expected, got %h", $time, m_tdata);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.irq_set !== want.irq_set) begin
                        mismatches++;
                        $display("%0t: irq_set mismatch, expected %h, got %h",
                                 $time, want.irq_set, got.irq_set);
                    end
                    for (int t = 0; t < 4; t++) begin
                        if (got.count[t] !== want.count[t]) begin
                            mismatches++;
                            $display("%0t: count%0d mismatch, expected %h, got %h",
                                     $time, t, want.count[t], got.count[t]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]      src;
        logic [3:0]      levels;
        known_t          none;
        gmtt_pkg::mode_t pick;
        none = '0;
        for (int t = 0; t < 4; t++) begin
            timer_mode[t]   = '0;
            timer_target[t] = '0;
            timer_count[t]  = '0;
        end

        directed_rows = '{
            evt_known(SRC_BUS, 4'b1111, 4'b0000, 16'd0),
            evt_known(gmtt_pkg::SRC_HBLANK, 4'b0000, 4'b0000, 16'd0),
            cfg_row(REG_MODE0, {6'd0, M_CNT | M_CMP}),
            cfg_row(REG_TARGET0, 16'd0),
            evt_known(SRC_BUS, 4'b0000, 4'b0001, 16'd1),
            cfg_row(REG_MODE1, 16'h03FF),
            cfg_row(REG_TARGET1, 16'hFFFF),
            cfg_row(REG_MODE2, {6'd0, M_CNT | M_CMP | M_GATE | M_HBCLK}),
            cfg_row(REG_TARGET2, 16'd2),
            cfg_row(REG_MODE3, {6'd0, M_CNT | M_GATE | M_B16}),
            cfg_row(REG_TARGET3, 16'hFFFF),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b0001),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b0010),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b1000),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b1010),
            evt_row(SRC_BUS16, 4'b0001),
            evt_row(SRC_BUS16, 4'b0100),
            evt_row(SRC_BUS256, 4'b1111),
            cfg_row(REG_MODE0, {6'd0, M_CNT | M_CMP | M_ZRET | M_GATE | M_VGATE | M_RISE}),
            cfg_row(REG_TARGET0, 16'd3),
            cfg_row(REG_MODE3, {6'd0, M_CNT | M_OVF | M_GATE | M_FALL | M_B16}),
            evt_row(SRC_BUS, 4'b0000),
            evt_row(SRC_BUS, 4'b0010),
            evt_row(SRC_BUS, 4'b1010),
            evt_row(SRC_BUS, 4'b1010),
            evt_row(SRC_BUS, 4'b1010),
            evt_row(SRC_BUS16, 4'b0100),
            evt_row(SRC_BUS16, 4'b0101),
            cfg_row(REG_MODE2, {6'd0, M_CNT | M_GATE | M_VGATE | M_HBCLK}),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b0010),
            evt_row(gmtt_pkg::SRC_HBLANK, 4'b0000),
            cfg_row(REG_MODE3, 16'd0),
            evt_row(SRC_BUS16, 4'b0000),
            cfg_row(REG_TARGET2, 16'd0),
            cfg_row(REG_MODE2, {6'd0, M_CNT | M_ZRET | M_B256}),
            evt_row(SRC_BUS256, 4'b0000)
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_event(directed_rows[i].src, directed_rows[i].levels,
                           directed_rows[i].known);
            end
        end

        // Long back-to-back run on the bus clock: overflow, compare, zero return and vblank gate.
        wait_idle();
        write_reg(REG_MODE0, {6'd0, M_CNT | M_OVF});
        write_reg(REG_MODE1, {6'd0, M_CNT | M_CMP});
        write_reg(REG_TARGET1, 16'hFFFF);
        write_reg(REG_MODE2, {6'd0, M_CNT | M_CMP | M_ZRET});
        write_reg(REG_TARGET2, 16'd40);
        write_reg(REG_MODE3, {6'd0, M_CNT | M_OVF | M_GATE | M_VGATE});
        sender_gappy = 1'b0;
        ready_pct = 100;
        for (int n = 0; n < LONG_ITEMS; n++) begin
            levels = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 3) != 0)
                levels[1] = 1'b0;
            send_event(SRC_BUS, levels, none);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            random_config();
            case (p)
                0:       begin sender_gappy = 1'b0; ready_pct = 100; end
                1:       begin sender_gappy = 1'b1; ready_pct = 60;  end
                2:       begin sender_gappy = 1'b0; ready_pct = 85;  holds_asked++; end
                3:       begin sender_gappy = 1'b1; ready_pct = 35;  end
                default: begin sender_gappy = 1'b1; ready_pct = 90;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mostly pick a source that some timer listens to
                pick = timer_mode[$urandom_range(0, 3)];
                src = ($urandom_range(0, 9) < 7) ? pick.clksel : 2'($urandom_range(0, 3));
                levels = 4'($urandom_range(0, 15));
                send_event(src, levels, none);
            end
        end

        wait_idle();
        $display("summary: %0d event items (%0d in the back-to-back run), %0d register writes",
                 events_sent, LONG_ITEMS, config_writes);
        $display("summary: %0d results compared across gate modes, stalls and hold-off",
                 results_seen);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
